// File: sv/ltps_pkg.sv
// ----------------------------------------------------------------------------
// ltps_pkg
// Shared types and constants of the raster to tiled pixel store.
// ----------------------------------------------------------------------------
package ltps_pkg;

  localparam int PIX_W      = 32;
  localparam int OUT_IDX_W  = 26;
  localparam int AREA_W     = 28;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int M_TDATA_W  = 64;

  localparam logic [1:0] LAYOUT_LINEAR = 2'd0;
  localparam logic [1:0] LAYOUT_TILED  = 2'd1;
  localparam logic [1:0] LAYOUT_SUPER  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYOUT_MODE = 3'd0,
    REG_DEST_X      = 3'd1,
    REG_DEST_Y      = 3'd2,
    REG_DEST_WIDTH  = 3'd3,
    REG_DEST_HEIGHT = 3'd4,
    REG_DEST_PITCH  = 3'd5,
    REG_SRC_WIDTH   = 3'd6,
    REG_SRC_HEIGHT  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  layout_mode;
    logic [12:0] dest_x;
    logic [12:0] dest_y;
    logic [13:0] dest_width;
    logic [13:0] dest_height;
    logic [13:0] dest_pitch;
    logic [13:0] src_width;
    logic [13:0] src_height;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

// File: sv/linear_to_tiled_pixel_store.sv
// ----------------------------------------------------------------------------
// linear_to_tiled_pixel_store
// Raster order pixel stream to destination word index for linear, 4x4 tiled
// and 64x64 super-tiled surfaces.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one 32-bit pixel per transaction, in raster order over
//   the source rectangle. Master side returns each pixel with its destination
//   word index; tlast marks the final pixel of the rectangle and tuser flags
//   an index not below dest_width * dest_height.
//   An accepted transaction passes the input register, the row multiply
//   register and the output register, in that order, to the master side. One
//   transaction per cycle is sustained while the master side does not stall;
//   the single row multiplier in the middle stage sets the stage depth.
//   A stalled master side holds the output register; the stages behind it
//   keep filling, and s_tready drops only when all three stages are full.
//   s_tready is high whenever the output register is empty or m_tready is high.
//   Reset empties the stages, clears the column and row counters and loads
//   the register defaults (linear layout, 256 x 256 surface and rectangle).
//   Write registers through cfg_we / cfg_index / cfg_data only while idle.
// ----------------------------------------------------------------------------
module linear_to_tiled_pixel_store #(
  parameter int COORD_BITS = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ltps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ltps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ltps_pkg::PIX_W-1:0]        s_tdata,   // [31:0] pixel_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ltps_pkg::M_TDATA_W-1:0]    m_tdata,   // [25:0] dest_index, [57:26] pixel_out
  output logic                              m_tlast,
  output logic                              m_tuser    // [0] out_of_range
);

  localparam int CW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
  localparam int PW = CW + 20;
  localparam int RW = CW + 6;

  ltps_pkg::cfg_t                  cfg;
  logic [ltps_pkg::AREA_W-1:0]     area;
  logic [CW-1:0]                   xc;
  logic [CW-1:0]                   yc;
  logic                            last;
  ltps_pkg::stage_ctl_t            in_ctl;
  ltps_pkg::stage_ctl_t            mul_ctl;
  logic                            mul_ready;
  logic [PW-1:0]                   prod;
  logic [RW-1:0]                   rest;
  logic [ltps_pkg::PIX_W-1:0]      pixel;

  assign in_ctl = '{valid: s_tvalid, last: last};

  ltps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .area      (area)
  );

  ltps_coord #(.COORD_BITS(COORD_BITS)) u_coord (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (s_tvalid && s_tready),
    .xc      (xc),
    .yc      (yc),
    .last    (last)
  );

  ltps_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ctl    (in_ctl),
    .in_ready  (s_tready),
    .pixel_in  (s_tdata),
    .xc        (xc),
    .yc        (yc),
    .out_ctl   (mul_ctl),
    .out_ready (mul_ready),
    .prod      (prod),
    .rest      (rest),
    .pixel     (pixel)
  );

  ltps_out #(.COORD_BITS(COORD_BITS)) u_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .area     (area),
    .in_ctl   (mul_ctl),
    .in_ready (mul_ready),
    .prod     (prod),
    .rest     (rest),
    .pixel    (pixel),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: sv/ltps_cfg.sv
// ----------------------------------------------------------------------------
// ltps_cfg
// Configuration register file and registered destination area.
// ----------------------------------------------------------------------------
module ltps_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ltps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ltps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ltps_pkg::cfg_t                    cfg,
  output logic [ltps_pkg::AREA_W-1:0]       area
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layout_mode <= ltps_pkg::LAYOUT_LINEAR;
      cfg.dest_x      <= 13'd0;
      cfg.dest_y      <= 13'd0;
      cfg.dest_width  <= 14'd256;
      cfg.dest_height <= 14'd256;
      cfg.dest_pitch  <= 14'd256;
      cfg.src_width   <= 14'd256;
      cfg.src_height  <= 14'd256;
    end else if (cfg_we) begin
      unique case (ltps_pkg::cfg_reg_t'(cfg_index))
        ltps_pkg::REG_LAYOUT_MODE: cfg.layout_mode <= cfg_data[1:0];
        ltps_pkg::REG_DEST_X:      cfg.dest_x      <= cfg_data[12:0];
        ltps_pkg::REG_DEST_Y:      cfg.dest_y      <= cfg_data[12:0];
        ltps_pkg::REG_DEST_WIDTH:  cfg.dest_width  <= cfg_data;
        ltps_pkg::REG_DEST_HEIGHT: cfg.dest_height <= cfg_data;
        ltps_pkg::REG_DEST_PITCH:  cfg.dest_pitch  <= cfg_data;
        ltps_pkg::REG_SRC_WIDTH:   cfg.src_width   <= cfg_data;
        ltps_pkg::REG_SRC_HEIGHT:  cfg.src_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    area <= ltps_pkg::AREA_W'(cfg.dest_width) * ltps_pkg::AREA_W'(cfg.dest_height);
  end

endmodule

// File: sv/ltps_coord.sv
// ----------------------------------------------------------------------------
// ltps_coord
// Column and row counters and destination coordinates of the next pixel.
// ----------------------------------------------------------------------------
module ltps_coord #(
  parameter  int COORD_BITS = 13,
  localparam int CW         = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1
) (
  input  logic            clk,
  input  logic            rst,
  input  ltps_pkg::cfg_t  cfg,
  input  logic            advance,
  output logic [CW-1:0]   xc,
  output logic [CW-1:0]   yc,
  output logic            last
);

  localparam int EW = (COORD_BITS + 1 > 14) ? COORD_BITS + 1 : 14;
  localparam logic [EW-1:0] CAP = EW'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] column_count_next;
  logic [COORD_BITS-1:0] row_count_next;
  logic [EW-1:0]         sw;
  logic [EW-1:0]         sh;
  logic [EW-1:0]         ew;
  logic [EW-1:0]         eh;
  logic [EW-1:0]         col_inc;
  logic [EW-1:0]         row_inc;
  logic                  row_end;
  logic                  rect_end;

  always_comb begin
    sw = EW'(cfg.src_width);
    sh = EW'(cfg.src_height);
    ew = (sw == '0) ? EW'(1) : ((sw > CAP) ? CAP : sw);
    eh = (sh == '0) ? EW'(1) : ((sh > CAP) ? CAP : sh);
    col_inc  = EW'(column_count) + EW'(1);
    row_inc  = EW'(row_count) + EW'(1);
    row_end  = col_inc >= ew;
    rect_end = row_inc >= eh;
    last     = row_end && rect_end;
    xc = CW'(cfg.dest_x) + CW'(column_count);
    yc = CW'(cfg.dest_y) + CW'(row_count);
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = rect_end ? '0 : row_inc[COORD_BITS-1:0];
    end else begin
      column_count_next = col_inc[COORD_BITS-1:0];
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// File: sv/ltps_mul.sv
// ----------------------------------------------------------------------------
// ltps_mul
// Input register and row product stage: row term times pitch or super-tile
// row stride, and the in-tile offset that the output stage adds to it.
// ----------------------------------------------------------------------------
module ltps_mul #(
  parameter  int COORD_BITS = 13,
  localparam int CW         = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1,
  localparam int PW         = CW + 20,
  localparam int RW         = CW + 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ltps_pkg::cfg_t                 cfg,
  input  ltps_pkg::stage_ctl_t           in_ctl,
  output logic                           in_ready,
  input  logic [ltps_pkg::PIX_W-1:0]     pixel_in,
  input  logic [CW-1:0]                  xc,
  input  logic [CW-1:0]                  yc,
  output ltps_pkg::stage_ctl_t           out_ctl,
  input  logic                           out_ready,
  output logic [PW-1:0]                  prod,
  output logic [RW-1:0]                  rest,
  output logic [ltps_pkg::PIX_W-1:0]     pixel
);

  ltps_pkg::stage_ctl_t          ctl1;
  logic [ltps_pkg::PIX_W-1:0]    pixel1;
  logic [CW-1:0]                 xc1;
  logic [CW-1:0]                 yc1;
  logic                          ready1;
  logic                          ready2;
  logic [CW-1:0]                 mul_a;
  logic [19:0]                   mul_b;
  logic [RW-1:0]                 rest_next;

  assign ready2   = !out_ctl.valid || out_ready;
  assign ready1   = !ctl1.valid || ready2;
  assign in_ready = ready1;

  always_comb begin
    mul_b = 20'(cfg.dest_pitch);
    case (cfg.layout_mode)
      ltps_pkg::LAYOUT_TILED: begin
        mul_a     = yc1 >> 2;
        rest_next = RW'({xc1[CW-1:2], yc1[1:0], xc1[1:0]});
      end
      ltps_pkg::LAYOUT_SUPER: begin
        mul_a     = yc1 >> 6;
        mul_b     = {cfg.dest_width, 6'b0};
        rest_next = {xc1[CW-1:6], yc1[5], xc1[5], yc1[4], xc1[4], yc1[3], xc1[3],
                     yc1[2], xc1[2], yc1[1:0], xc1[1:0]};
      end
      default: begin
        mul_a     = yc1;
        rest_next = RW'(xc1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid    <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else begin
      if (ready1) begin
        ctl1.valid <= in_ctl.valid;
      end
      if (ready2) begin
        out_ctl.valid <= ctl1.valid;
      end
    end
    if (ready1 && in_ctl.valid) begin
      ctl1.last <= in_ctl.last;
      pixel1    <= pixel_in;
      xc1       <= xc;
      yc1       <= yc;
    end
    if (ready2 && ctl1.valid) begin
      out_ctl.last <= ctl1.last;
      pixel        <= pixel1;
      prod         <= PW'(mul_a) * PW'(mul_b);
      rest         <= rest_next;
    end
  end

endmodule

// File: sv/ltps_out.sv
// ----------------------------------------------------------------------------
// ltps_out
// Final index sum, range check against the destination area and output
// register of the master side.
// ----------------------------------------------------------------------------
module ltps_out #(
  parameter  int COORD_BITS = 13,
  localparam int CW         = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1,
  localparam int PW         = CW + 20,
  localparam int RW         = CW + 6,
  localparam int IW         = CW + 22
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ltps_pkg::cfg_t                    cfg,
  input  logic [ltps_pkg::AREA_W-1:0]       area,
  input  ltps_pkg::stage_ctl_t              in_ctl,
  output logic                              in_ready,
  input  logic [PW-1:0]                     prod,
  input  logic [RW-1:0]                     rest,
  input  logic [ltps_pkg::PIX_W-1:0]        pixel,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ltps_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  output logic                              m_tuser
);

  logic [IW-1:0] idx;
  logic          oor;

  assign in_ready = !m_tvalid || m_tready;

  always_comb begin
    if (cfg.layout_mode == ltps_pkg::LAYOUT_TILED) begin
      idx = IW'({prod, 2'b00}) + IW'(rest);
    end else begin
      idx = IW'(prod) + IW'(rest);
    end
    oor = idx >= IW'(area);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ctl.valid) begin
      m_tdata <= {6'b0, pixel, idx[ltps_pkg::OUT_IDX_W-1:0]};
      m_tlast <= in_ctl.last;
      m_tuser <= oor;
    end
  end

endmodule

// File: sv/ltps_checker.sv
// ----------------------------------------------------------------------------
// ltps_checker
// Port-level checks of the pixel store, bound to the top level.
// ----------------------------------------------------------------------------
module ltps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ltps_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic                              m_tlast,
  input logic                              m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output not empty after reset");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("slave side stalled while output can drain");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("master transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("master payload changed while stalled");

endmodule

bind linear_to_tiled_pixel_store ltps_checker u_ltps_checker (.*);

// File: tb/placement_checker.sv
// ----------------------------------------------------------------------------
// placement_checker
// Watches the register port and both stream channels of the raster to tiled
// pixel store, works out the destination word index, pixel, rectangle end and
// range flag of every accepted pixel, and compares them in order with the
// results on the master side.
// ----------------------------------------------------------------------------
module placement_checker
  import ltps_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  m_tlast,
  input  logic                  m_tuser,
  output int                    errors,
  output int                    pending,
  output int                    placed,
  output int                    rect_ends,
  output int                    clipped
);

  localparam longint unsigned EXTENT_CAP = 64'd1 << COORD_BITS;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic [PIX_W-1:0]     pixel;
    logic                 last;
    logic                 clip;
  } placement_t;

  cfg_t                  shadow;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  placement_t            placement_q[$];

  function automatic logic [63:0] clamp_extent(input logic [13:0] v);
    if (v == 0) return 64'd1;
    if (v > EXTENT_CAP) return EXTENT_CAP;
    return 64'(v);
  endfunction

  function automatic placement_t place(input logic [PIX_W-1:0] pix);
    logic [63:0] xc;
    logic [63:0] yc;
    logic [63:0] idx;
    logic        row_end;
    logic        rect_end;
    placement_t  p;
    xc       = 64'(shadow.dest_x) + 64'(column);
    yc       = 64'(shadow.dest_y) + 64'(row);
    row_end  = 64'(column) + 64'd1 >= clamp_extent(shadow.src_width);
    rect_end = 64'(row) + 64'd1 >= clamp_extent(shadow.src_height);
    case (shadow.layout_mode)
      LAYOUT_TILED: begin
        idx = (((yc >> 2) * 64'(shadow.dest_pitch) + (yc & 64'd3)) << 2)
            + ((xc >> 2) << 4) + (xc & 64'd3);
      end
      LAYOUT_SUPER: begin
        idx = (yc >> 6) * (64'(shadow.dest_width) << 6)
            + (64'(yc[5]) << 11) + (64'(yc[4]) << 9) + (64'(yc[3]) << 7)
            + (64'(yc[2]) << 5) + (64'(yc[1:0]) << 2)
            + (xc >> 6) * 64'd4096
            + (64'(xc[5]) << 10) + (64'(xc[4]) << 8) + (64'(xc[3]) << 6)
            + (64'(xc[2]) << 4) + 64'(xc[1:0]);
      end
      default: begin
        idx = yc * 64'(shadow.dest_pitch) + xc;
      end
    endcase
    p.index = idx[OUT_IDX_W-1:0];
    p.pixel = pix;
    p.last  = row_end && rect_end;
    p.clip  = idx >= 64'(shadow.dest_width) * 64'(shadow.dest_height);
    if (row_end) begin
      column = '0;
      row    = rect_end ? '0 : row + 1'b1;
    end else begin
      column = column + 1'b1;
    end
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      shadow = '{layout_mode: LAYOUT_LINEAR, dest_x: '0, dest_y: '0,
                 dest_width: 14'd256, dest_height: 14'd256, dest_pitch: 14'd256,
                 src_width: 14'd256, src_height: 14'd256};
      column = '0;
      row    = '0;
      placement_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (placement_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got tdata %h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = placement_q.pop_front();
          check_field("dest_index", 64'(want.index), 64'(m_tdata[25:0]));
          check_field("pixel_out", 64'(want.pixel), 64'(m_tdata[57:26]));
          check_field("last_of_rect", 64'(want.last), 64'(m_tlast));
          check_field("out_of_range", 64'(want.clip), 64'(m_tuser));
          placed++;
          if (want.last) rect_ends++;
          if (want.clip) clipped++;
        end
      end
      if (s_tvalid && s_tready) begin
        placement_q.push_back(place(s_tdata));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LAYOUT_MODE: shadow.layout_mode = cfg_data[1:0];
          REG_DEST_X:      shadow.dest_x      = cfg_data[12:0];
          REG_DEST_Y:      shadow.dest_y      = cfg_data[12:0];
          REG_DEST_WIDTH:  shadow.dest_width  = cfg_data;
          REG_DEST_HEIGHT: shadow.dest_height = cfg_data;
          REG_DEST_PITCH:  shadow.dest_pitch  = cfg_data;
          REG_SRC_WIDTH:   shadow.src_width   = cfg_data;
          REG_SRC_HEIGHT:  shadow.src_height  = cfg_data;
          default: ;
        endcase
      end
    end
    pending = placement_q.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the raster to tiled pixel store through directed and random register
// settings across all layouts, with random gaps and stalls on both channels
// and one long output hold-off; the placement checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import ltps_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         HOLD_CYCLES    = 80;
  localparam logic [1:0] LAYOUT_SPARE   = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  cfg_reg_t              cfg_index = REG_LAYOUT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  int errors;
  int pending;
  int placed;
  int rect_ends;
  int clipped;

  int idle_pct  = 0;
  int stall_pct = 0;
  int phases    = 0;
  int quiet     = 0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int idle_tab[4]  = '{0, 45, 0, 7};
  int stall_tab[4] = '{0, 0, 45, 7};

  linear_to_tiled_pixel_store dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  placement_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .errors    (errors),
    .pending   (pending),
    .placed    (placed),
    .rect_ends (rect_ends),
    .clipped   (clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL linear_to_tiled_pixel_store");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [13:0] lm, dx, dy, dw, dh, dp, sw, sh);
    put_reg(REG_LAYOUT_MODE, lm);
    put_reg(REG_DEST_X, dx);
    put_reg(REG_DEST_Y, dy);
    put_reg(REG_DEST_WIDTH, dw);
    put_reg(REG_DEST_HEIGHT, dh);
    put_reg(REG_DEST_PITCH, dp);
    put_reg(REG_SRC_WIDTH, sw);
    put_reg(REG_SRC_HEIGHT, sh);
    cfg_we <= 1'b0;
  endtask

  // Drain, reprogram, then stream n pixels; counters carry over between phases.
  task automatic run_phase(input logic [13:0] lm, dx, dy, dw, dh, dp, sw, sh,
                           input int n, input int idle, input int stall,
                           input bit hold);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    program_regs(lm, dx, dy, dw, dh, dp, sw, sh);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_req = 1'b1;
    for (int k = 0; k < n; k++) begin
      send_pixel((k % 16 == 0) ? 32'h0 : (k % 16 == 1) ? 32'hFFFF_FFFF : $urandom());
    end
    phases++;
  endtask

  initial begin
    logic [13:0] lm, dx, dy, dw, dh, dp, sw, sh;
    wait (!rst);
    @(posedge clk);

    send_pixel(32'h0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hA5A5_5A5A);

    run_phase(14'(LAYOUT_LINEAR), 14'd0, 14'd0, 14'd16, 14'd16, 14'd16,
              14'd2, 14'd2, 4, 0, 0, 1'b0);
    run_phase(14'(LAYOUT_TILED), 14'h1FFF, 14'h1FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF,
              14'd3, 14'd1, 3, 0, 0, 1'b0);
    run_phase(14'(LAYOUT_SUPER), 14'd62, 14'd61, 14'd64, 14'd256, 14'd1,
              14'd3, 14'd2, 6, 0, 0, 1'b0);
    run_phase({12'hFFF, LAYOUT_SPARE}, 14'd5, 14'd7, 14'd100, 14'd100, 14'd100,
              14'd4, 14'd4, 2, 0, 0, 1'b0);
    run_phase(14'(LAYOUT_TILED), 14'd1, 14'd2, 14'd64, 14'd64, 14'd8,
              14'd0, 14'd0, 2, 0, 0, 1'b0);
    run_phase(14'(LAYOUT_LINEAR), 14'd0, 14'd0, 14'd0, 14'd256, 14'd256,
              14'h3FFF, 14'h2000, 2, 0, 0, 1'b0);
    run_phase(14'(LAYOUT_SUPER), 14'd60, 14'd3, 14'd100, 14'd100, 14'd0,
              14'd5, 14'd2, 3, 0, 0, 1'b0);

    for (int p = 0; p < 14; p++) begin
      lm = 14'($urandom_range(16383));
      dx = ($urandom_range(3) == 0) ? 14'($urandom_range(16383)) : 14'($urandom_range(70));
      dy = ($urandom_range(3) == 0) ? 14'($urandom_range(16383)) : 14'($urandom_range(70));
      dw = ($urandom_range(2) == 0) ? 14'($urandom_range(16383))
                                    : 14'(64 * $urandom_range(1, 4));
      dh = ($urandom_range(2) == 0) ? 14'($urandom_range(16383))
                                    : 14'($urandom_range(1, 300));
      dp = ($urandom_range(3) == 0) ? 14'($urandom_range(16383))
                                    : 14'($urandom_range(1, 300));
      sw = ($urandom_range(9) == 0) ? 14'($urandom_range(16383)) : 14'($urandom_range(9));
      sh = 14'($urandom_range(6));
      run_phase(lm, dx, dy, dw, dh, dp, sw, sh, 36, idle_tab[p % 4], stall_tab[p % 4],
                1'b0);
    end

    run_phase(14'(LAYOUT_LINEAR), 14'd3, 14'd4, 14'd64, 14'd64, 14'd64,
              14'd8, 14'd3, 40, 0, 0, 1'b1);

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d pixels over %0d register settings: all layout codes,",
             placed, phases + 1);
    $display("zero and oversized extents, %0d rectangle ends, %0d out-of-range indexes.",
             rect_ends, clipped);
    if (errors == 0 && pending == 0) begin
      $display("PASS linear_to_tiled_pixel_store");
    end else begin
      $display("FAIL linear_to_tiled_pixel_store");
    end
    $finish;
  end

endmodule
